### sv/ihd_pkg.sv
package ihd_pkg;

    // TCP option kinds that the walker knows
    localparam logic [7:0] KIND_NOP   = 8'd1;
    localparam logic [7:0] KIND_MSS   = 8'd2;
    localparam logic [7:0] KIND_WS    = 8'd3;
    localparam logic [7:0] KIND_SACKP = 8'd4;
    localparam logic [7:0] KIND_TS    = 8'd8;
    localparam logic [7:0] KIND_MPTCP = 8'd30;

    // First TCP byte that belongs to the options area
    localparam int OPT_START = 20;

    // Bit positions in the IP mismatch mask
    localparam int IP_HLEN   = 0;
    localparam int IP_DSCP   = 1;
    localparam int IP_TOTLEN = 2;
    localparam int IP_ID     = 3;
    localparam int IP_FLAGS  = 4;
    localparam int IP_OFFSET = 5;
    localparam int IP_TTL    = 6;
    localparam int IP_PROTO  = 7;
    localparam int IP_CSUM   = 8;

    // Bit positions in the TCP mismatch mask
    localparam int TCP_SPORT  = 0;
    localparam int TCP_DPORT  = 1;
    localparam int TCP_SEQ    = 2;
    localparam int TCP_HLEN   = 3;
    localparam int TCP_FLAGS  = 4;
    localparam int TCP_WINDOW = 5;
    localparam int TCP_CSUM   = 6;
    localparam int TCP_URGPTR = 7;

    // Option descriptor: size, first compared byte, mismatch bit
    typedef struct packed {
        logic       known;
        logic [3:0] size;
        logic [3:0] first;
        logic [2:0] bit_idx;
    } ihd_opt_info_t;

    // Control from the datapath to the option walker
    typedef struct packed {
        logic step;     // a word is consumed this cycle
        logic restart;  // the word opens a new section
        logic take;     // the word is an option byte
        logic flush;    // the word is the last one
    } ihd_walk_ctrl_t;

    function automatic ihd_opt_info_t opt_info(input logic [7:0] kind);
        ihd_opt_info_t info;
        info = '0;
        case (kind)
            KIND_NOP: begin
                info = '{known: 1'b1, size: 4'd1, first: 4'd0, bit_idx: 3'd0};
            end
            KIND_MSS: begin
                info = '{known: 1'b1, size: 4'd4, first: 4'd2, bit_idx: 3'd1};
            end
            KIND_WS: begin
                info = '{known: 1'b1, size: 4'd3, first: 4'd2, bit_idx: 3'd2};
            end
            KIND_SACKP: begin
                info = '{known: 1'b1, size: 4'd2, first: 4'd1, bit_idx: 3'd3};
            end
            KIND_TS: begin
                info = '{known: 1'b1, size: 4'd10, first: 4'd2, bit_idx: 3'd4};
            end
            KIND_MPTCP: begin
                info = '{known: 1'b1, size: 4'd8, first: 4'd1, bit_idx: 3'd5};
            end
            default: begin
                info = '0;
            end
        endcase
        return info;
    endfunction

endpackage

### sv/ihd_opt_walker.sv
module ihd_opt_walker (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ihd_pkg::ihd_walk_ctrl_t ctrl,
    input  logic [7:0]              sent_byte,
    input  logic [7:0]              recv_byte,
    output logic [5:0]              opt_flags
);
    import ihd_pkg::*;

    logic [7:0]    kind_reg, kind_next, kind_cur;
    logic [3:0]    idx_reg, idx_next, idx_cur;
    logic [3:0]    size_reg, size_next, size_cur;
    logic [5:0]    acc_reg, acc_next;
    logic [3:0]    idx_inc;
    logic          diff;
    ihd_opt_info_t info_s;
    ihd_opt_info_t info_h;

    // Drop the option in progress when a new section starts
    assign kind_cur = ctrl.restart ? 8'd0 : kind_reg;
    assign idx_cur  = ctrl.restart ? 4'd0 : idx_reg;
    assign size_cur = ctrl.restart ? 4'd0 : size_reg;
    assign diff     = (sent_byte != recv_byte);
    assign info_s   = opt_info(sent_byte);
    assign info_h   = opt_info(kind_cur);
    assign idx_inc  = idx_cur + 4'd1;

    // Walk one option byte: kind byte, or a byte inside a known option
    always_comb begin
        kind_next = kind_cur;
        idx_next  = idx_cur;
        size_next = size_cur;
        acc_next  = acc_reg;
        if (ctrl.take) begin
            if (idx_cur == 4'd0) begin
                if (info_s.known) begin
                    kind_next = sent_byte;
                    size_next = info_s.size;
                    if (info_s.first == 4'd0 && diff) begin
                        acc_next[info_s.bit_idx] = 1'b1;
                    end
                    idx_next = (info_s.size > 4'd1) ? 4'd1 : 4'd0;
                end
            end else if (!info_h.known) begin
                idx_next = 4'd0;
            end else begin
                if (idx_cur >= info_h.first && diff) begin
                    acc_next[info_h.bit_idx] = 1'b1;
                end
                idx_next = (idx_inc >= size_cur) ? 4'd0 : idx_inc;
            end
        end
    end

    assign opt_flags = acc_next;

    // Hold walker state; clear it after the last word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= '0;
            idx_reg  <= '0;
            size_reg <= '0;
            acc_reg  <= '0;
        end else if (ctrl.step) begin
            if (ctrl.flush) begin
                kind_reg <= '0;
                idx_reg  <= '0;
                size_reg <= '0;
                acc_reg  <= '0;
            end else begin
                kind_reg <= kind_next;
                idx_reg  <= idx_next;
                size_reg <= size_next;
                acc_reg  <= acc_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_in_option: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 4'd0 |-> idx_reg < size_reg)
        else $error("option byte index beyond option size");
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.step && ctrl.flush |=> idx_reg == 4'd0 && acc_reg == 6'd0)
        else $error("walker not cleared after last word");
    a_acc_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.step && !ctrl.flush |=> (acc_reg & $past(acc_reg)) == $past(acc_reg))
        else $error("option mismatch bit lost");
`endif

endmodule

### sv/ip_tcp_header_diff.sv
// IP/TCP header difference checker.
// Input channel (s_): one word per byte position, a sent byte and the byte
// quoted back in the ICMP reply, a section flag (0 IP header, 1 TCP
// segment) and a last flag. A change of section restarts the position.
// Result channel (m_): one word per last-flagged input word, carrying the
// IP, TCP and option mismatch masks gathered since the previous result.
// Throughput: one input word per cycle, sustained, while results are taken.
// A result is registered: it shows on m_valid when the last word moves from
// the input register into the result register.
// When the receiver stalls, a pending result is held and the block keeps
// taking words until a second last word reaches the input register; that
// word waits there and s_ready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers and clears the
// position, section, option walker and the accumulated mismatch bits.
// Bytes at positions of MAX_SECTION_BYTES or more in a section are ignored;
// a last flag on such a byte still closes the comparison.
module ip_tcp_header_diff #(
    parameter int MAX_SECTION_BYTES = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_sent_byte,
    input  logic [7:0] s_recv_byte,
    input  logic       s_section,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [8:0] m_ip_mismatch,
    output logic [7:0] m_tcp_mismatch,
    output logic [5:0] m_option_mismatch
);
    import ihd_pkg::*;

    localparam int PW = $clog2(MAX_SECTION_BYTES + 1);

    // Input register
    logic          in_valid_reg;
    logic [7:0]    sent_reg;
    logic [7:0]    recv_reg;
    logic          sec_reg;
    logic          last_reg;

    // Comparison state
    logic [PW-1:0] pos_reg;
    logic          in_tcp_reg;
    logic [7:0]    prev_sent_reg;
    logic [7:0]    prev_recv_reg;
    logic          fdiff_reg, fdiff_next;
    logic [8:0]    ip_acc_reg, ip_acc_next;
    logic [7:0]    tcp_acc_reg, tcp_acc_next;

    // Result register
    logic          m_valid_reg;
    logic [8:0]    ip_out_reg;
    logic [7:0]    tcp_out_reg;
    logic [5:0]    opt_out_reg;

    logic           advance;
    logic           restart;
    logic [PW-1:0]  pos_cur;
    logic           fdiff_cur;
    logic           in_range;
    logic           fixed_area;
    logic           diff;
    logic           prev_diff;
    logic           swap_ok;
    logic [4:0]     pos_lo;
    logic [5:0]     opt_flags;
    ihd_walk_ctrl_t walk_ctrl;

    // Consume the held word unless it is a last word and the result is stuck
    assign advance = in_valid_reg && (!last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Restart position and field tracking on a section change
    assign restart   = (sec_reg != in_tcp_reg);
    assign pos_cur   = restart ? '0 : pos_reg;
    assign fdiff_cur = restart ? 1'b0 : fdiff_reg;
    assign in_range  = (pos_cur < PW'(MAX_SECTION_BYTES));
    assign fixed_area = in_range && (pos_cur < PW'(OPT_START));
    assign pos_lo    = pos_cur[4:0];

    assign diff      = (sent_reg != recv_reg);
    assign prev_diff = (prev_sent_reg != prev_recv_reg);
    assign swap_ok   = (prev_sent_reg == recv_reg) && (sent_reg == prev_recv_reg);

    // Judge fixed header fields on their final byte
    always_comb begin
        ip_acc_next  = ip_acc_reg;
        tcp_acc_next = tcp_acc_reg;
        fdiff_next   = fdiff_cur;
        if (fixed_area && !sec_reg) begin
            case (pos_lo)
                5'd0:  if (diff) ip_acc_next[IP_HLEN] = 1'b1;
                5'd1:  if (diff) ip_acc_next[IP_DSCP] = 1'b1;
                5'd3:  if (diff || prev_diff) ip_acc_next[IP_TOTLEN] = 1'b1;
                5'd5:  if ((diff || prev_diff) && !swap_ok) ip_acc_next[IP_ID] = 1'b1;
                5'd6:  if (diff) ip_acc_next[IP_FLAGS] = 1'b1;
                5'd7:  if (diff) ip_acc_next[IP_OFFSET] = 1'b1;
                5'd8:  if (diff) ip_acc_next[IP_TTL] = 1'b1;
                5'd9:  if (diff) ip_acc_next[IP_PROTO] = 1'b1;
                5'd11: if ((diff || prev_diff) && !swap_ok) ip_acc_next[IP_CSUM] = 1'b1;
                default: ;
            endcase
        end else if (fixed_area && sec_reg) begin
            case (pos_lo)
                5'd1:  if (diff || prev_diff) tcp_acc_next[TCP_SPORT] = 1'b1;
                5'd3:  if (diff || prev_diff) tcp_acc_next[TCP_DPORT] = 1'b1;
                5'd4:  fdiff_next = diff;
                5'd5:  if (diff) fdiff_next = 1'b1;
                5'd6:  if (diff) fdiff_next = 1'b1;
                5'd7:  if (diff || fdiff_cur) tcp_acc_next[TCP_SEQ] = 1'b1;
                5'd12: if (diff) tcp_acc_next[TCP_HLEN] = 1'b1;
                5'd13: if (diff) tcp_acc_next[TCP_FLAGS] = 1'b1;
                5'd15: if (diff || prev_diff) tcp_acc_next[TCP_WINDOW] = 1'b1;
                5'd17: if (diff || prev_diff) tcp_acc_next[TCP_CSUM] = 1'b1;
                5'd19: if (diff || prev_diff) tcp_acc_next[TCP_URGPTR] = 1'b1;
                default: ;
            endcase
        end
    end

    // Option bytes go to the walker
    assign walk_ctrl.step    = advance;
    assign walk_ctrl.restart = restart;
    assign walk_ctrl.take    = sec_reg && in_range && !fixed_area;
    assign walk_ctrl.flush   = last_reg;

    ihd_opt_walker u_opt_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (walk_ctrl),
        .sent_byte (sent_reg),
        .recv_byte (recv_reg),
        .opt_flags (opt_flags)
    );

    // Load the input register whenever it is free or being consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            sent_reg <= s_sent_byte;
            recv_reg <= s_recv_byte;
            sec_reg  <= s_section;
            last_reg <= s_last;
        end
    end

    // Advance comparison state; clear it after the last word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            in_tcp_reg    <= 1'b0;
            prev_sent_reg <= '0;
            prev_recv_reg <= '0;
            fdiff_reg     <= 1'b0;
            ip_acc_reg    <= '0;
            tcp_acc_reg   <= '0;
        end else if (advance) begin
            if (last_reg) begin
                pos_reg       <= '0;
                in_tcp_reg    <= 1'b0;
                prev_sent_reg <= '0;
                prev_recv_reg <= '0;
                fdiff_reg     <= 1'b0;
                ip_acc_reg    <= '0;
                tcp_acc_reg   <= '0;
            end else begin
                in_tcp_reg  <= sec_reg;
                fdiff_reg   <= fdiff_next;
                ip_acc_reg  <= ip_acc_next;
                tcp_acc_reg <= tcp_acc_next;
                if (in_range) begin
                    pos_reg       <= pos_cur + PW'(1);
                    prev_sent_reg <= sent_reg;
                    prev_recv_reg <= recv_reg;
                end else begin
                    pos_reg <= pos_cur;
                end
            end
        end
    end

    // Capture the result on a last word; drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && last_reg) begin
            ip_out_reg  <= ip_acc_next;
            tcp_out_reg <= tcp_acc_next;
            opt_out_reg <= opt_flags;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_ip_mismatch     = ip_out_reg;
    assign m_tcp_mismatch    = tcp_out_reg;
    assign m_option_mismatch = opt_out_reg;

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && last_reg |=> m_valid_reg)
        else $error("last word did not produce a result");
    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && last_reg |=> pos_reg == '0 && !in_tcp_reg && ip_acc_reg == 9'd0)
        else $error("state not cleared after last word");
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PW'(MAX_SECTION_BYTES))
        else $error("byte position beyond section limit");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(ip_out_reg))
        else $error("pending result lost or overwritten");
`endif

endmodule
